FILE: sv/egbp_pkg.sv
// Shared constants for the Elias gamma bit packer.
// No dependencies; used by egbp_back, elias_gamma_bit_packer and the testbench.
package egbp_pkg;

   // Output byte width and the most bits held back between items
   localparam int BYTE_W = 8;
   localparam int PEND_W = BYTE_W - 1;

   // Bits needed to name a position inside one byte
   localparam int BIT_POS_W = $clog2(BYTE_W);

endpackage

FILE: sv/elias_gamma_bit_packer.sv
// Elias gamma bit packer, top level: front end, queue and byte packer.
// Depends on egbp_pkg, egbp_front, egbp_fifo, egbp_back.
//
//   channel | ports                                  | direction
//   req     | req_valid/ready, req_value, req_end_of_list | in
//   rsp     | rsp_valid/ready, rsp_out_byte, rsp_final_byte | out
//
// An item passes through the front register, then waits in a two-entry queue.
// The packer takes one item per cycle when it holds fewer than eight bits and no flush
// is pending, then sends one byte per cycle while the output is not stalled: an item of
// n > 0 significant bits yields floor((p + 2n-1)/8) full bytes (p pending bits), plus
// the final byte when the item also ends the list.
// Reset clears the pending bits, the queue and the output register.
// A stalled output holds the packer; the queue and front register keep taking items until they fill.
module elias_gamma_bit_packer #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [31:0]                 req_value,
   input  logic                        req_end_of_list,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [egbp_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_final_byte
);

   localparam int CODE_W = 2 * VALUE_WIDTH - 1;
   localparam int LEN_W = $clog2(CODE_W + 1);
   localparam int Q_W = CODE_W + LEN_W + 1;

   logic              fe_valid, fe_ready;
   logic [CODE_W-1:0] fe_code;
   logic [LEN_W-1:0]  fe_len;
   logic              fe_last;

   logic              q_valid, q_ready;
   logic [Q_W-1:0]    q_data;
   logic [CODE_W-1:0] q_code;
   logic [LEN_W-1:0]  q_len;
   logic              q_last;

   egbp_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_value  (req_value),
      .in_last   (req_end_of_list),
      .out_valid (fe_valid),
      .out_ready (fe_ready),
      .out_code  (fe_code),
      .out_len   (fe_len),
      .out_last  (fe_last)
   );

   egbp_fifo #(
      .DATA_W(Q_W),
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_data   ({fe_code, fe_len, fe_last}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   assign {q_code, q_len, q_last} = q_data;

   egbp_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_code         (q_code),
      .q_len          (q_len),
      .q_last         (q_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_final_byte (rsp_final_byte)
   );

   // The final byte never carries a full eight bits
   a_final_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_byte |-> !rsp_out_byte[egbp_pkg::BYTE_W-1])
      else $error("final byte has its top bit set");

   // Reset leaves nothing in flight at the ends
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !fe_valid)
      else $error("item in flight right after reset");

   // Input stalls only when the front register is held by a full queue
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> fe_valid && !fe_ready)
      else $error("input stalled without a full queue");

endmodule

FILE: sv/egbp_front.sv
// Front end: takes an item, finds the value's significant length and builds its
// gamma code as an LSB-first bit string. Standalone; no package use.
module egbp_front #(
   parameter int VALUE_WIDTH = 32,
   localparam int CODE_W = 2 * VALUE_WIDTH - 1,
   localparam int LEN_W = $clog2(CODE_W + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [31:0]       in_value,
   input  logic              in_last,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CODE_W-1:0] out_code,
   output logic [LEN_W-1:0]  out_len,
   output logic              out_last
);

   localparam int NUM_W = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] value;
   logic [NUM_W-1:0]       num_bits;
   logic [CODE_W-1:0]      rev;
   logic [LEN_W-1:0]       shamt;
   logic [CODE_W-1:0]      code;
   logic [LEN_W-1:0]       len;

   logic              valid_ff, valid_in;
   logic [CODE_W-1:0] code_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              last_ff;

   // Bits above VALUE_WIDTH are ignored
   assign value = in_value[VALUE_WIDTH-1:0];

   // Leading-one position, value reversed into the top of the code field.
   // Stream bit j of the code is value bit 2n-2-j, zero above the leading one,
   // so one right shift by 2*(VALUE_WIDTH-n) lines the code up at bit 0.
   always_comb begin
      num_bits = '0;
      rev = '0;
      for (int i = 0; i < VALUE_WIDTH; i++) begin
         if (value[i]) begin
            num_bits = NUM_W'(i + 1);
         end
         rev[CODE_W-1-i] = value[i];
      end
      shamt = LEN_W'(2 * (VALUE_WIDTH - int'(num_bits)));
      code = rev >> shamt;
      // zero has no code and adds no bits
      if (num_bits == '0) begin
         len = '0;
      end else begin
         len = LEN_W'(2 * int'(num_bits) - 1);
      end
   end

   // One register stage toward the queue
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         code_ff <= code;
         len_ff  <= len;
         last_ff <= in_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_code  = code_ff;
   assign out_len   = len_ff;
   assign out_last  = last_ff;

endmodule

FILE: sv/egbp_fifo.sv
// Short queue between the front end and the packer.
// Standalone; no package use.
module egbp_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: sv/egbp_back.sv
// Back end: appends each code to the pending bits and sends bytes one per cycle while the
// output is not stalled, plus the flushed final byte. Uses egbp_pkg.
module egbp_back #(
   parameter int VALUE_WIDTH = 32,
   localparam int CODE_W = 2 * VALUE_WIDTH - 1,
   localparam int LEN_W = $clog2(CODE_W + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   output logic                       q_ready,
   input  logic [CODE_W-1:0]          q_code,
   input  logic [LEN_W-1:0]           q_len,
   input  logic                       q_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [egbp_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_final_byte
);

   localparam int ACC_W = CODE_W + egbp_pkg::PEND_W;
   localparam int CNT_W = $clog2(ACC_W + 1);

   // Bit window: stream bit k of the window sits at acc bit k, bits above cnt are 0
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_ff, last_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [egbp_pkg::BYTE_W-1:0] rsp_byte_ff;
   logic                        rsp_final_ff;

   logic slot_free;
   logic emit;
   logic emit_final;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Full bytes first, then the flush, otherwise take the next code
   always_comb begin
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      q_ready    = 1'b0;
      emit       = 1'b0;
      emit_final = 1'b0;
      priority if (cnt_ff >= CNT_W'(egbp_pkg::BYTE_W)) begin
         if (slot_free) begin
            emit   = 1'b1;
            acc_in = acc_ff >> egbp_pkg::BYTE_W;
            cnt_in = cnt_ff - CNT_W'(egbp_pkg::BYTE_W);
         end
      end else if (last_ff) begin
         if (slot_free) begin
            emit       = 1'b1;
            emit_final = 1'b1;
            acc_in     = '0;
            cnt_in     = '0;
            last_in    = 1'b0;
         end
      end else begin
         q_ready = 1'b1;
         if (q_valid) begin
            acc_in  = acc_ff | (ACC_W'(q_code) << cnt_ff[egbp_pkg::BIT_POS_W-1:0]);
            cnt_in  = cnt_ff + CNT_W'(q_len);
            last_in = q_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         last_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff  <= acc_ff[egbp_pkg::BYTE_W-1:0];
         rsp_final_ff <= emit_final;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_final_byte = rsp_final_ff;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for elias_gamma_bit_packer: random and directed values in,
// packed code bytes out, each byte checked against a built-in gamma packing tracker.
// Depends on egbp_pkg and the elias_gamma_bit_packer RTL.
module testbench;

   localparam int VALUE_WIDTH    = 32;
   localparam int ITEM_COUNT     = 310;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 20;
   localparam int PRESSURE_AT    = 40;
   localparam int PRESSURE_HOLD  = 120;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [egbp_pkg::BYTE_W-1:0] code;
      logic                        last;
   } coded_byte_type;

   // Tracks the pending bits and queues the code bytes each value must produce
   class gamma_byte_tracker_type;
      logic [egbp_pkg::PEND_W-1:0]    held_bits  = '0;
      logic [egbp_pkg::BIT_POS_W-1:0] held_count = '0;
      coded_byte_type                 expected_bytes[$];
      int                             errors     = 0;

      function void push_bit(logic b);
         logic [egbp_pkg::BYTE_W-1:0] word;
         word = {1'b0, held_bits};
         word[held_count] = b;
         if (held_count == egbp_pkg::BYTE_W - 1) begin
            expected_bytes.push_back('{word, 1'b0});
            held_bits  = '0;
            held_count = '0;
         end else begin
            held_bits  = word[egbp_pkg::PEND_W-1:0];
            held_count = held_count + 1'b1;
         end
      endfunction

      // Accepted input item: n-1 zeros, then the n significant bits, MSB first
      function void note_value(logic [31:0] value, logic end_of_list);
         logic [31:0] v;
         int          n;
         v = value;
         if (VALUE_WIDTH < 32)
            v = value & ((32'd1 << VALUE_WIDTH) - 1);
         n = 0;
         for (int i = 0; i < 32; i++)
            if (v[i]) n = i + 1;
         for (int i = 1; i < n; i++)
            push_bit(1'b0);
         for (int i = n - 1; i >= 0; i--)
            push_bit(v[i]);
         if (end_of_list) begin
            // flushed byte, zero padded above the pending bits
            expected_bytes.push_back('{{1'b0, held_bits}, 1'b1});
            held_bits  = '0;
            held_count = '0;
         end
      endfunction

      // Accepted result item: compare with the oldest expected byte
      function void check_byte(logic [egbp_pkg::BYTE_W-1:0] code, logic last);
         coded_byte_type exp_byte;
         if (expected_bytes.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected byte: code=%02h final=%0b", code, last);
            return;
         end
         exp_byte = expected_bytes.pop_front();
         if (exp_byte.code !== code || exp_byte.last !== last) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("byte mismatch: expected code=%02h final=%0b, got code=%02h final=%0b",
                        exp_byte.code, exp_byte.last, code, last);
         end
      endfunction
   endclass

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic [31:0]                   req_value       = '0;
   logic                          req_end_of_list = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic [egbp_pkg::BYTE_W-1:0]   rsp_out_byte;
   logic                          rsp_final_byte;

   gamma_byte_tracker_type tracker = new();
   int                     items_sent  = 0;
   int                     bytes_taken = 0;
   int                     idle_cycles = 0;

   elias_gamma_bit_packer #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_end_of_list(req_end_of_list),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_final_byte (rsp_final_byte)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one value, wait for it to be taken, then idle for a random gap
   task automatic send_value(input logic [31:0] value, input logic end_of_list);
      int gap;
      req_value       <= value;
      req_end_of_list <= end_of_list;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      tracker.note_value(value, end_of_list);
      items_sent++;
      // a stretch of back-to-back items in the middle of the run
      gap = (items_sent >= 120 && items_sent < 180) ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid       <= 1'b0;
         req_value       <= $urandom;
         req_end_of_list <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random value with a random number of significant bits; zero now and then
   function automatic logic [31:0] random_value();
      int          n;
      logic [31:0] bits;
      if ($urandom_range(0, 11) == 0)
         return '0;
      n    = $urandom_range(1, 32);
      bits = $urandom;
      if (n < 32)
         bits = bits & ((32'd1 << n) - 1);
      bits[n-1] = 1'b1;
      return bits;
   endfunction

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_byte(rsp_out_byte, rsp_final_byte);
   end

   // Watchdog: cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[elias_gamma_bit_packer] ERROR");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold-off so the block backs up
   initial begin : receiver
      int hold;
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         bytes_taken++;
         if (bytes_taken == PRESSURE_AT)
            hold = PRESSURE_HOLD;
         else if (bytes_taken >= 200 && bytes_taken < 300)
            hold = 0;
         else
            hold = $urandom_range(0, 9);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin : stimulus
      int list_len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // aligned end straight out of reset, then an ignored zero
      send_value(32'h0000_0000, 1'b1);
      send_value(32'h0000_0000, 1'b0);
      // one-bit codes, final byte padded
      send_value(32'h0000_0001, 1'b0);
      send_value(32'h0000_0001, 1'b1);
      // widest codes: seven pending bits, then eight full bytes plus the final one
      send_value(32'hFFFF_FFFF, 1'b0);
      send_value(32'h8000_0000, 1'b1);
      // exactly one byte filled at the end of the list
      send_value(32'h0000_0001, 1'b0);
      send_value(32'h0000_0008, 1'b1);
      // zero carrying the end marker while bits are pending
      send_value(32'h0000_0005, 1'b0);
      send_value(32'h0000_0000, 1'b1);
      send_value(32'h0000_0002, 1'b0);
      send_value(32'h0000_0003, 1'b0);
      send_value(32'h7FFF_FFFF, 1'b0);
      send_value(32'h5555_5555, 1'b0);
      send_value(32'hAAAA_AAAA, 1'b1);
      send_value(32'h0000_0100, 1'b0);
      send_value(32'hFFFF_FFFE, 1'b1);

      // random lists of values, each closed by an end marker
      while (items_sent < ITEM_COUNT) begin
         list_len = $urandom_range(1, 12);
         for (int k = 0; k < list_len; k++)
            send_value(random_value(), k == list_len - 1);
      end
      req_valid <= 1'b0;

      while (tracker.expected_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (tracker.errors == 0)
         $display("[elias_gamma_bit_packer] OK");
      else
         $display("[elias_gamma_bit_packer] ERROR");
      $finish;
   end

endmodule
